// ===== src/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round helpers for the MD5 digest block.
// ----------------------------------------------------------------------------
package md5_pkg;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hEFCDAB89;
   localparam logic [31:0] INIT_C = 32'h98BADCFE;
   localparam logic [31:0] INIT_D = 32'h10325476;
   localparam logic [7:0]  PAD_MARK = 8'h80;

   // four working or chaining words, a in the lowest bits
   typedef struct packed {
      logic [31:0] d;
      logic [31:0] c;
      logic [31:0] b;
      logic [31:0] a;
   } md5_work_type;

   localparam md5_work_type INIT_WORDS = '{d: INIT_D, c: INIT_C, b: INIT_B, a: INIT_A};

   // sine-derived additive constant for each round
   function automatic logic [31:0] sine_k(input logic [5:0] idx);
      logic [31:0] k;
      case (idx)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   // left rotate amount per stage and round-within-group
   function automatic logic [4:0] rot_amt(input logic [1:0] stage, input logic [1:0] q);
      logic [4:0] n;
      case ({stage, q})
         4'h0: n = 5'd7;   4'h1: n = 5'd12;  4'h2: n = 5'd17;  4'h3: n = 5'd22;
         4'h4: n = 5'd5;   4'h5: n = 5'd9;   4'h6: n = 5'd14;  4'h7: n = 5'd20;
         4'h8: n = 5'd4;   4'h9: n = 5'd11;  4'hA: n = 5'd16;  4'hB: n = 5'd23;
         4'hC: n = 5'd6;   4'hD: n = 5'd10;  4'hE: n = 5'd15;  default: n = 5'd21;
      endcase
      return n;
   endfunction

   // message word used by a round
   function automatic logic [3:0] word_sel(input logic [5:0] rnd);
      logic [3:0] q;
      logic [3:0] g;
      q = rnd[3:0];
      case (rnd[5:4])
         2'd0:    g = q;
         2'd1:    g = 4'(q * 4'd5) + 4'd1;
         2'd2:    g = 4'(q * 4'd3) + 4'd5;
         default: g = 4'(q * 4'd7);
      endcase
      return g;
   endfunction

   function automatic logic [31:0] mix(input logic [1:0] stage, input logic [31:0] b,
                                       input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      case (stage)
         2'd0:    f = (b & c) | (~b & d);
         2'd1:    f = (d & b) | (~d & c);
         2'd2:    f = b ^ c ^ d;
         default: f = c ^ (b | ~d);
      endcase
      return f;
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] w;
      w = {x, x} << n;
      return w[63:32];
   endfunction

endpackage

// ===== src/md5_round.sv =====
// ----------------------------------------------------------------------------
// md5_round
// One MD5 round: mix function, constant and message word add, rotate, shift.
// ----------------------------------------------------------------------------
module md5_round (
   input  logic [5:0]           round_idx,
   input  logic [31:0]          msg_word,
   input  md5_pkg::md5_work_type work_cur,
   output md5_pkg::md5_work_type work_nxt
);
   import md5_pkg::*;

   logic [1:0]  stage;
   logic [31:0] sum;
   logic [31:0] rot;

   assign stage = round_idx[5:4];
   assign sum   = work_cur.a + mix(stage, work_cur.b, work_cur.c, work_cur.d)
                  + sine_k(round_idx) + msg_word;
   assign rot   = rotl(sum, rot_amt(stage, round_idx[1:0]));

   assign work_nxt.a = work_cur.d;
   assign work_nxt.b = work_cur.b + rot;
   assign work_nxt.c = work_cur.b;
   assign work_nxt.d = work_cur.c;

endmodule

// ===== src/md5_message_digest.sv =====
// ----------------------------------------------------------------------------
// md5_message_digest
// Streaming MD5 hash: bytes in, one 128-bit digest out per message.
// ----------------------------------------------------------------------------
// Message bytes are taken one per cycle on the req_ side while req_tready is
// high; req_tuser high marks a transfer that carries a byte, req_tlast ends the
// message (a bare end marker with req_tuser low is allowed, also for an empty
// message). Bytes land in a 16-word block memory; every 64th byte starts a
// compression (one memory prefetch, 64 rounds, one chaining add), during
// which req_tready is low. At the end of a message the block inserts the pad
// bytes itself, one per cycle outside compressions, then the 64-bit bit
// length, which takes one or two compressions, and then loads the digest into
// the rsp_ register from the emit state once that register is free. A pending
// digest does not hold off the next message; only a second digest waits until
// the first is taken. No new bytes are taken while a block is compressed, a
// limit set by the single round unit and the block memory.
// ----------------------------------------------------------------------------
module md5_message_digest (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tuser,   // [0] has_byte
   input  logic         req_tlast,   // end_of_message
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata    // [63:0] digest_first_half, [127:64] digest_second_half
);
   import md5_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_PAD,
      ST_EMIT
   } state_type;

   state_type    state_ff, state_in;
   state_type    ret_ff, ret_in;
   logic [5:0]   pos_ff, pos_in;
   logic [5:0]   round_ff, round_in;
   logic [63:0]  count_ff, count_in;
   logic         mark_ff, mark_in;
   logic         len_ff, len_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [127:0] rsp_data_ff, rsp_data_in;
   md5_work_type chain_ff, chain_in;
   md5_work_type work_ff, work_in;
   md5_work_type work_rnd;
   logic [31:0]  word_ff, word_in;

   logic         put_en;
   logic [7:0]   put_data;
   logic         mem_we;
   logic [3:0]   rd_addr;
   logic [5:0]   rd_rnd;
   logic [31:0]  rd_data_ff;
   logic [31:0]  blk_mem [16];

   md5_round u_round (
      .round_idx (round_ff),
      .msg_word  (rd_data_ff),
      .work_cur  (work_ff),
      .work_nxt  (work_rnd)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // prefetch the word of the next round
   assign rd_rnd  = (state_ff == ST_ROUND) ? round_ff + 6'd1 : '0;
   assign rd_addr = word_sel(rd_rnd);
   assign mem_we  = put_en && (pos_ff[1:0] == 2'd3);

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      pos_in       = pos_ff;
      round_in     = round_ff;
      count_in     = count_ff;
      mark_in      = mark_ff;
      len_in       = len_ff;
      chain_in     = chain_ff;
      work_in      = work_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      put_en       = 1'b0;
      put_data     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser) begin
                  put_en   = 1'b1;
                  put_data = req_tdata;
                  count_in = count_ff + 64'd8;
               end
               if (req_tuser && (pos_ff == 6'd63)) begin
                  state_in = ST_LOAD;
                  ret_in   = req_tlast ? ST_PAD : ST_IDLE;
               end else if (req_tlast) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            put_en = 1'b1;
            if (!mark_ff) begin
               put_data = PAD_MARK;
               mark_in  = 1'b1;
            end else if (len_ff || (pos_ff == 6'd56)) begin
               // length bytes, least significant first
               put_data = count_ff[{pos_ff[2:0], 3'b000} +: 8];
               len_in   = 1'b1;
            end
            if (pos_ff == 6'd63) begin
               state_in = ST_LOAD;
               ret_in   = len_ff ? ST_EMIT : ST_PAD;
            end
         end
         ST_LOAD: begin
            work_in  = chain_ff;
            round_in = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            work_in  = work_rnd;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            chain_in.a = chain_ff.a + work_ff.a;
            chain_in.b = chain_ff.b + work_ff.b;
            chain_in.c = chain_ff.c + work_ff.c;
            chain_in.d = chain_ff.d + work_ff.d;
            state_in   = ret_ff;
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = chain_ff;
               rsp_valid_in = 1'b1;
               chain_in     = INIT_WORDS;
               count_in     = '0;
               mark_in      = 1'b0;
               len_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (put_en) begin
         pos_in = pos_ff + 6'd1;
      end

      word_in = word_ff;
      if (put_en) begin
         case (pos_ff[1:0])
            2'd0:    word_in[7:0]   = put_data;
            2'd1:    word_in[15:8]  = put_data;
            2'd2:    word_in[23:16] = put_data;
            default: word_in[31:24] = put_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         pos_ff       <= '0;
         round_ff     <= '0;
         count_ff     <= '0;
         mark_ff      <= 1'b0;
         len_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         chain_ff     <= INIT_WORDS;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         pos_ff       <= pos_in;
         round_ff     <= round_in;
         count_ff     <= count_in;
         mark_ff      <= mark_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      word_ff     <= word_in;
      rsp_data_ff <= rsp_data_in;
   end

   // block word memory, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         blk_mem[pos_ff[5:2]] <= word_in;
      end
      rd_data_ff <= blk_mem[rd_addr];
   end

endmodule
